// ===== hdl/lfsa_pkg.sv =====
// Shared constants, command codes and the table write bundle of the slot allocator.
package lfsa_pkg;

    // Table geometry.
    localparam int SLOTS       = 64;
    localparam int HANDLE_BITS = 32;

    // Field widths of the ports.
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 6;
    localparam int LIMIT_W = 7;
    localparam int HIN_W   = 32;
    localparam int HOUT_W  = 32;

    // Internal widths.
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int LIM_W   = $clog2(SLOTS + 1);

    // The free search is split into groups of GROUP slots.
    localparam int GROUP   = 8;
    localparam int GRP_W   = $clog2(GROUP);
    localparam int NGROUPS = (SLOTS + GROUP - 1) / GROUP;
    localparam int PAD     = NGROUPS * GROUP;

    localparam logic [HANDLE_BITS-1:0] RESERVED_MARK = HANDLE_BITS'(1);
    localparam logic [SLOT_W-1:0]      TOP_RESET     = SLOT_W'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 2'd0,
        CMD_PUT    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_SET    = 2'd3
    } t_cmd;

    // One write into the slot table; used is the new in-use flag of the slot.
    typedef struct packed {
        logic                   en;
        logic [SLOT_W-1:0]      addr;
        logic [HANDLE_BITS-1:0] data;
        logic                   used;
    } t_tbl_wr;

endpackage

// ===== hdl/lfsa_table.sv =====
// Slot table: handle memory with registered read and a per-slot in-use bitmap.
module lfsa_table import lfsa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [SLOT_W-1:0]      i_rd_addr,
    output logic [HANDLE_BITS-1:0] o_rd_data,
    input  t_tbl_wr                i_wr,
    output logic [SLOTS-1:0]       o_used
);

    logic [HANDLE_BITS-1:0] r_mem [SLOTS];
    logic [HANDLE_BITS-1:0] r_rd_data;
    logic [SLOTS-1:0]       r_used;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // A slot whose bit is clear reads as free regardless of the memory contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used[i_wr.addr] <= i_wr.used;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_used    = r_used;

endmodule

// ===== hdl/lfsa_search.sv =====
// Two-level registered priority encoder that finds the lowest free slot in a window.
module lfsa_search import lfsa_pkg::*; (
    input  logic              i_clk,
    input  logic [SLOTS-1:0]  i_used,
    input  logic [SLOT_W-1:0] i_start,
    input  logic [LIM_W-1:0]  i_limit,
    output logic              o_found,
    output logic [SLOT_W-1:0] o_slot
);

    logic [PAD-1:0]       w_used_pad;
    logic [PAD-1:0]       w_cand;
    logic [NGROUPS-1:0]   n_any;
    logic [GRP_W-1:0]     n_low [NGROUPS];
    logic [NGROUPS-1:0]   r_any;
    logic [GRP_W-1:0]     r_low [NGROUPS];
    logic                 n_found;
    logic [SLOT_W-1:0]    n_slot;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_slot;

    // Padding slots past the end of the table count as taken.
    assign w_used_pad = PAD'(i_used) | ~PAD'({SLOTS{1'b1}});

    always_comb begin
        for (int s = 0; s < PAD; s++) begin
            w_cand[s] = !w_used_pad[s] && (s >= int'(i_start)) && (s < int'(i_limit));
        end
    end

    // First level: lowest candidate inside each group.
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            n_any[g] = |w_cand[g*GROUP +: GROUP];
            n_low[g] = '0;
            for (int b = GROUP - 1; b >= 0; b--) begin
                if (w_cand[g*GROUP + b]) begin
                    n_low[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= n_any;
        r_low <= n_low;
    end

    // Second level: lowest group that has a candidate.
    always_comb begin
        n_found = |r_any;
        n_slot  = '0;
        for (int g = NGROUPS - 1; g >= 0; g--) begin
            if (r_any[g]) begin
                n_slot = SLOT_W'(g * GROUP) + SLOT_W'(r_low[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_slot  <= n_slot;
    end

    assign o_found = r_found;
    assign o_slot  = r_slot;

endmodule

// ===== hdl/lowest_free_slot_allocator_core.sv =====
// Top level of the lowest-free slot allocator: command sequencer, hint and mark registers.
//
// Each input word is one command (get, put, lookup or set) and produces exactly one output
// word. The block works on one word at a time: it accepts the word, runs the first level of
// the free-slot priority encoder (which also reads the handle memory for a lookup), runs the
// second level of the encoder, and then commits the update and loads the output register.
// A new word is accepted as soon as the sequencer is back in idle, even while the previous
// result still sits in the output register; a word only stalls in its commit cycle while
// the output register is still full. The slot table is cleared at reset by the in-use
// bitmap, so no clearing pass is needed and the block accepts words right after reset.
module lowest_free_slot_allocator_core import lfsa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [IDX_W-1:0]   i_slot_index,
    input  logic [LIMIT_W-1:0] i_search_limit,
    input  logic [HIN_W-1:0]   i_handle_in,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic [IDX_W-1:0]   o_slot_out,
    output logic [HOUT_W-1:0]  o_handle_out,
    output logic [IDX_W-1:0]   o_highest_in_use
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_PICK,
        ST_DONE
    } t_state;

    t_state                 r_state;

    // The command word being worked on.
    t_cmd                   r_cmd;
    logic [IDX_W-1:0]       r_idx;
    logic [LIM_W-1:0]       r_lim;
    logic [HANDLE_BITS-1:0] r_hin;

    // Search hint and highest-used mark.
    logic [SLOT_W-1:0]      r_start;
    logic [SLOT_W-1:0]      r_top;
    logic [SLOT_W-1:0]      n_start;
    logic [SLOT_W-1:0]      n_top;

    // Output register.
    logic                   r_out_valid;
    logic                   r_status;
    logic [IDX_W-1:0]       r_slot_out;
    logic [HOUT_W-1:0]      r_handle_out;
    logic                   n_status;
    logic [IDX_W-1:0]       n_slot_out;
    logic [HOUT_W-1:0]      n_handle_out;

    logic                   w_accept;
    logic                   w_out_take;
    logic                   w_commit;
    logic [LIM_W-1:0]       w_lim_sat;
    logic                   w_in_range;
    logic [SLOT_W-1:0]      w_addr;
    logic [HANDLE_BITS-1:0] w_rd_data;
    logic [SLOTS-1:0]       w_used;
    logic                   w_found;
    logic [SLOT_W-1:0]      w_slot;
    t_tbl_wr                w_wr;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_take = r_out_valid && !i_stall;
    // The result is written once the output register is free or being emptied.
    assign w_commit   = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    // A limit past the table end is clamped to the table size.
    assign w_lim_sat = (32'(i_search_limit) > 32'(SLOTS)) ? LIM_W'(SLOTS)
                                                          : LIM_W'(i_search_limit);

    assign w_in_range = 32'(r_idx) < 32'(SLOTS);
    assign w_addr     = SLOT_W'(r_idx);

    lfsa_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == ST_SRCH),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data),
        .i_wr      (w_wr),
        .o_used    (w_used)
    );

    lfsa_search u_search (
        .i_clk   (i_clk),
        .i_used  (w_used),
        .i_start (r_start),
        .i_limit (r_lim),
        .o_found (w_found),
        .o_slot  (w_slot)
    );

    // Commit: table update, hint and mark, and the result word.
    always_comb begin
        w_wr         = '0;
        n_start      = r_start;
        n_top        = r_top;
        n_status     = 1'b0;
        n_slot_out   = r_idx;
        n_handle_out = '0;
        unique case (r_cmd)
            CMD_GET: begin
                if (w_found) begin
                    w_wr.en    = w_commit;
                    w_wr.addr  = w_slot;
                    w_wr.data  = RESERVED_MARK;
                    w_wr.used  = 1'b1;
                    n_start    = w_slot;
                    if (w_slot > r_top) begin
                        n_top = w_slot;
                    end
                    n_slot_out = IDX_W'(w_slot);
                end else begin
                    n_status   = 1'b1;
                    n_slot_out = '0;
                end
            end
            CMD_PUT: begin
                if (w_in_range) begin
                    w_wr.en   = w_commit;
                    w_wr.addr = w_addr;
                    w_wr.data = '0;
                    w_wr.used = 1'b0;
                    if (w_addr < r_start) begin
                        n_start = w_addr;
                    end
                end
            end
            CMD_LOOKUP: begin
                if (w_in_range && w_used[w_addr]) begin
                    n_handle_out = HOUT_W'(w_rd_data);
                end
            end
            CMD_SET: begin
                if (w_in_range) begin
                    w_wr.en   = w_commit;
                    w_wr.addr = w_addr;
                    w_wr.data = r_hin;
                    w_wr.used = (r_hin != '0);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, hint and mark, and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= '0;
            r_top       <= TOP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    r_state <= ST_PICK;
                end
                ST_PICK: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_commit) begin
                        r_state      <= ST_IDLE;
                        r_start      <= n_start;
                        r_top        <= n_top;
                        r_out_valid  <= 1'b1;
                        r_status     <= n_status;
                        r_slot_out   <= n_slot_out;
                        r_handle_out <= n_handle_out;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Command word capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_cmd);
            r_idx <= i_slot_index;
            r_lim <= w_lim_sat;
            r_hin <= HANDLE_BITS'(i_handle_in);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_slot_out       = r_slot_out;
    assign o_handle_out     = r_handle_out;
    assign o_highest_in_use = IDX_W'(r_top);

    // The highest-used mark never goes down.
    a_top_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top >= $past(r_top))
        else $error("highest-used mark decreased");

    // A successful get reserves a slot inside the search window.
    a_get_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_cmd == CMD_GET && w_found) |->
        (w_slot >= r_start) && (32'(w_slot) < 32'(r_lim)) && !w_used[w_slot])
        else $error("get reserved a slot outside the window or already in use");

    // After a successful get the reserved slot is marked in use.
    a_get_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_cmd == CMD_GET && w_found) |=> w_used[$past(w_slot)])
        else $error("reserved slot not marked in use");

    // The table is written only in the commit cycle.
    a_write_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> w_commit)
        else $error("table write outside commit");

endmodule
